// ===== rtl/gsc_pkg.sv =====
// Shared types and constants of the gradient sharpness check unit.
// No dependencies.
`default_nettype none
package gsc_pkg;
  localparam int MaxWidth = 2048;
  localparam int ColW = 11;
  localparam int FracBits = 4;
  localparam int TotalW = 36;
  localparam int MetricW = 14;
  localparam int DimW = 12;
  localparam int SqW = 17 + 2 * FracBits;
  localparam int RootW = SqW / 2 + 1;
  localparam int RootSteps = (SqW + 1) / 2;
  localparam int AreaW = 23;
  localparam int QuotW = TotalW;
  localparam logic [MetricW-1:0] MetricMax = '1;

  localparam logic [1:0] CFG_WIDTH = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_THRESH = 2'd2;

  typedef struct packed {
    logic load;       // take a pixel, start its work
    logic root_step;  // one square root step
    logic add_term;   // accumulate and update position
    logic div_start;  // start the final divide
    logic div_step;   // one divide step
  } gsc_cmd_t;

  typedef struct packed {
    logic root_done;
    logic div_done;
    logic frame_end;  // current pixel ends the frame
  } gsc_sts_t;
endpackage
`default_nettype wire

// ===== rtl/gsc_ctrl.sv =====
// Controller of the gradient sharpness check unit: sequences pixel work,
// square root steps and the final divide. Depends on gsc_pkg.
`default_nettype none
module gsc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic             out_busy,
  input  wire gsc_pkg::gsc_sts_t sts,
  output gsc_pkg::gsc_cmd_t     cmd,
  output logic                  emit
);
  import gsc_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_ROOT = 3'd1, S_ADD = 3'd2,
                         S_DIV = 3'd3, S_EMIT = 3'd4;
  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    emit = 1'b0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_done) state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add_term = 1'b1;
        if (sts.frame_end) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_busy) begin
          emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/gsc_datapath.sv =====
// Datapath of the gradient sharpness check unit: line store, gradients,
// iterative square root, accumulator and restoring divider. Depends on gsc_pkg.
`default_nettype none
module gsc_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire gsc_pkg::gsc_cmd_t         cmd,
  output gsc_pkg::gsc_sts_t              sts,
  input  wire logic [7:0]                pixel,
  input  wire logic [gsc_pkg::DimW-1:0]  width_cfg,
  input  wire logic [gsc_pkg::DimW-1:0]  height_cfg,
  output logic [gsc_pkg::QuotW-1:0]      quotient
);
  import gsc_pkg::*;

  logic [7:0] row_mem [MaxWidth];
  logic [7:0] above_r, right_r, pix_r;
  logic [ColW-1:0] col_r;
  logic [ColW:0] row_r;
  logic [DimW-1:0] w_use, h_use;
  logic [TotalW-1:0] total_r;

  assign w_use = (width_cfg < DimW'(2)) ? DimW'(2) :
                 (width_cfg > DimW'(MaxWidth)) ? DimW'(MaxWidth) : width_cfg;
  assign h_use = (height_cfg < DimW'(2)) ? DimW'(2) :
                 (height_cfg > DimW'(2048)) ? DimW'(2048) : height_cfg;

  // Reads of col and col+1, both registered; the mem is written at col.
  logic [ColW-1:0] col_p1;
  assign col_p1 = col_r + ColW'(1);
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_mem[col_r] <= pixel;
      above_r <= row_mem[col_r];
      right_r <= row_mem[col_p1];
      pix_r <= pixel;
    end
  end

  logic last_col;
  assign last_col = ({1'b0, col_r} + 12'd1) >= w_use;

  // Gradients from registered values.
  logic [7:0] dx, dy;
  assign dx = (pix_r >= above_r) ? pix_r - above_r : above_r - pix_r;
  assign dy = (right_r >= above_r) ? right_r - above_r : above_r - right_r;

  // Square root, two radicand bits per step; radicand sits in rad_r[SqW:1]
  // so that the bit pairs line up with the top two bits.
  logic [SqW-1:0] rem_r;
  logic [RootW-1:0] root_r;
  logic [SqW+1:0] rad_r;
  logic [$clog2(RootSteps+1)-1:0] step_r;
  logic first_r;
  logic [RootW+1:0] tsub;
  logic [RootW+1:0] rem_top;
  assign rem_top = {rem_r[RootW-1:0], rad_r[SqW+1:SqW]};
  assign tsub = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r <= 1'b1;
      step_r <= '0;
      rem_r <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      if (first_r) begin
        first_r <= 1'b0;
        rad_r <= {(({9'd0, dx} * {9'd0, dx}) + ({9'd0, dy} * {9'd0, dy})),
                  {(2 * FracBits){1'b0}}, 2'b00} >> 1;
      end else begin
        if (rem_top >= tsub) begin
          rem_r <= SqW'(rem_top - tsub);
          root_r <= {root_r[RootW-2:0], 1'b1};
        end else begin
          rem_r <= SqW'(rem_top);
          root_r <= {root_r[RootW-2:0], 1'b0};
        end
        rad_r <= {rad_r[SqW-1:0], 2'b00};
        step_r <= step_r + 1'b1;
      end
    end
  end
  assign sts.root_done = !first_r && (step_r == ($bits(step_r))'(RootSteps - 1));

  // Term, accumulate with saturation, position update.
  logic [TotalW:0] sum;
  assign sum = {1'b0, total_r} + (TotalW+1)'(root_r) +
               ((TotalW+1)'({1'b0, dx} + {1'b0, dy}) << FracBits);
  logic do_term;
  assign do_term = (row_r != '0) && !last_col;
  assign sts.frame_end = last_col && ((row_r + 12'd1) >= h_use);

  // Restoring divider.
  logic [TotalW-1:0] dvd_r, q_r;
  logic [AreaW:0] part_r;
  logic [AreaW-1:0] area_r;
  logic [5:0] dcnt_r;
  logic [AreaW:0] pshift;
  assign pshift = {part_r[AreaW-1:0], dvd_r[TotalW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      total_r <= '0;
    end else if (cmd.add_term) begin
      if (do_term) begin
        total_r <= sum[TotalW] ? '1 : sum[TotalW-1:0];
      end
      if (last_col) begin
        col_r <= '0;
        if (sts.frame_end) begin
          row_r <= '0;
          total_r <= '0;
        end else row_r <= row_r + 1'b1;
      end else col_r <= col_p1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r <= (do_term && sum[TotalW]) ? '1 : (do_term ? sum[TotalW-1:0] : total_r);
      area_r <= AreaW'(w_use * h_use);
      part_r <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      if (pshift >= {1'b0, area_r}) begin
        part_r <= pshift - {1'b0, area_r};
        q_r <= {q_r[TotalW-2:0], 1'b1};
      end else begin
        part_r <= pshift;
        q_r <= {q_r[TotalW-2:0], 1'b0};
      end
      dvd_r <= {dvd_r[TotalW-2:0], 1'b0};
      dcnt_r <= dcnt_r + 1'b1;
    end
  end
  assign sts.div_done = (dcnt_r == 6'(TotalW - 1));
  assign quotient = q_r;
endmodule
`default_nettype wire

// ===== rtl/gradient_sharpness_check_unit.sv =====
// Top level of the gradient sharpness check unit: config registers, output
// register, controller and datapath. Depends on gsc_pkg, gsc_ctrl, gsc_datapath.
//
// Usage: gray pixels of one frame enter on in_* in raster order. Each pixel
// is one transaction; before in_tready returns the block runs a load, a
// radicand setup, a 13-step iterative square root and an accumulate. After
// the last pixel of a frame a 36-step restoring divider forms the average;
// out_tvalid rises once the divide is done and the output register is free,
// and the result (metric, pass flag) then sits in the output register until
// out_tready takes it. While the output register is full and another result
// is ready, the block holds and does not accept pixels.
// Frame size and threshold are written through cfg_* while the block is idle.
// Synchronous reset clears position, accumulator and config to defaults
// (640 x 480, threshold 14.0); the line store is not cleared.
`default_nettype none
module gradient_sharpness_check_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] gray_pixel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [13:0] sharpness_metric, [14] is_sharp
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [13:0] cfg_data
);
  import gsc_pkg::*;

  logic [DimW-1:0] width_r, height_r;
  logic [MetricW-1:0] thresh_r;
  gsc_cmd_t cmd;
  gsc_sts_t sts;
  logic emit;
  logic [QuotW-1:0] quotient;
  logic [MetricW-1:0] metric;
  logic [15:0] out_data_r;
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= DimW'(640);
      height_r <= DimW'(480);
      thresh_r <= MetricW'(224);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WIDTH: width_r <= cfg_data[DimW-1:0];
        CFG_HEIGHT: height_r <= cfg_data[DimW-1:0];
        CFG_THRESH: thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gsc_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .out_busy(out_valid_r && !out_tready), .sts, .cmd, .emit
  );

  gsc_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .pixel(in_tdata),
    .width_cfg(width_r), .height_cfg(height_r), .quotient
  );

  assign metric = (quotient > QuotW'(MetricMax)) ? MetricMax : quotient[MetricW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (emit) out_data_r <= {1'b0, (metric >= thresh_r), metric};
  end
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
endmodule
`default_nettype wire
